// ===== hdl/bse_pkg.sv =====
package bse_pkg;

	localparam int MAX_ITEMS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int QUEUE_DEPTH   = 4;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     keep;
		logic                     ovf;
	} entry_t;

endpackage

// ===== hdl/bse_front.sv =====
module bse_front #(
	parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [bse_pkg::DATA_W-1:0] value,
	input  logic                             last_in,
	input  logic                             push,
	input  logic                             q_full,
	output logic                             q_push,
	output bse_pkg::entry_t                  q_entry
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             keep;
	logic             take;

	assign take   = push && !q_full;
	assign keep   = (count_q < CNT_W'(MAX_ITEMS));
	assign q_push = take;

	always_comb begin
		q_entry.value = value;
		q_entry.last  = last_in;
		q_entry.keep  = keep;
		q_entry.ovf   = ovf_q || !keep;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (last_in) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				if (keep) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/bse_fifo.sv =====
module bse_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  bse_pkg::entry_t wr_data,
	output logic            full,
	input  logic            rd,
	output bse_pkg::entry_t rd_data,
	output logic            empty
);

	localparam int PTR_W = $clog2(bse_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(bse_pkg::QUEUE_DEPTH + 1);

	bse_pkg::entry_t  mem_q [bse_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(bse_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/bse_sorter.sv =====
module bse_sorter #(
	parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bse_pkg::entry_t                   q_entry,
	input  logic                              q_empty,
	output logic                              q_pop,
	output logic signed [bse_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out,
	output logic                              overflow,
	output logic                              empty,
	input  logic                              pop
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W = $clog2(MAX_ITEMS);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                       state_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [CNT_W-1:0]                 pass_q;
	logic                             phase_q;
	logic                             ovf_q;
	logic                             oval_q;
	logic signed [bse_pkg::DATA_W-1:0] cell_q   [MAX_ITEMS];
	logic signed [bse_pkg::DATA_W-1:0] cell_nxt [MAX_ITEMS];
	logic                             emit_go;

	assign q_pop   = (state_q == ST_LOAD) && !q_empty;
	assign empty   = !oval_q;
	assign emit_go = (state_q == ST_EMIT) && (!oval_q || pop);

	always_comb begin
		cell_nxt = cell_q;
		for (int i = 0; i < MAX_ITEMS - 1; i++) begin
			if ((i[0] == phase_q) && (CNT_W'(i + 1) < cnt_q) && (cell_q[i] > cell_q[i+1])) begin
				cell_nxt[i]   = cell_q[i+1];
				cell_nxt[i+1] = cell_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (q_pop && q_entry.keep) begin
					cell_q[cnt_q[IDX_W-1:0]] <= q_entry.value;
				end
			end
			ST_SORT: begin
				if (pass_q != cnt_q) begin
					cell_q <= cell_nxt;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					sorted_value <= cell_q[0];
					last_out     <= (cnt_q == CNT_W'(1));
					overflow     <= ovf_q;
					for (int i = 0; i < MAX_ITEMS - 1; i++) begin
						cell_q[i] <= cell_q[i+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			pass_q  <= '0;
			phase_q <= 1'b0;
			ovf_q   <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			if (pop && oval_q && !emit_go) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (q_entry.keep) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (q_entry.last) begin
							ovf_q   <= q_entry.ovf;
							pass_q  <= '0;
							phase_q <= 1'b0;
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (pass_q == cnt_q) begin
						state_q <= ST_EMIT;
					end else begin
						pass_q  <= pass_q + CNT_W'(1);
						phase_q <= !phase_q;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						oval_q <= 1'b1;
						cnt_q  <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== hdl/bubble_sort_engine.sv =====
// A set of n items reaches the sorter through a 4-entry queue and loads one item a cycle
// while the queue is not empty, is sorted in odd-even transposition passes, then emits one
// result a cycle while the output is empty or popped. The single sort array takes a new
// set only after its last result; the front takes next-set items while the queue has room.
// Reset (arst_n low, asynchronous) empties the queue and the output register and clears counts.
module bubble_sort_engine #(
	parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [bse_pkg::DATA_W-1:0] value,
	input  logic                              last_in,
	input  logic                              push,
	output logic                              full,
	output logic signed [bse_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_out,
	output logic                              overflow,
	output logic                              empty,
	input  logic                              pop
);

	bse_pkg::entry_t wr_entry;
	bse_pkg::entry_t rd_entry;
	logic            q_push;
	logic            q_pop;
	logic            q_empty;

	bse_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.last_in (last_in),
		.push    (push),
		.q_full  (full),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	bse_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (wr_entry),
		.full    (full),
		.rd      (q_pop),
		.rd_data (rd_entry),
		.empty   (q_empty)
	);

	bse_sorter #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_sorter (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_entry      (rd_entry),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.overflow     (overflow),
		.empty        (empty),
		.pop          (pop)
	);

endmodule
